FILE: src/demand_page_fault_resolver_unit_macros.svh
// assertion macros for the page fault resolver
`ifndef DEMAND_PAGE_FAULT_RESOLVER_UNIT_MACROS_SVH
`define DEMAND_PAGE_FAULT_RESOLVER_UNIT_MACROS_SVH

`ifndef SYNTH
`define DPFR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("dpfr assertion failed");
`define DPFR_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("dpfr assertion failed");
`else
`define DPFR_ASSERT(lbl, clk, rst, prop)
`define DPFR_ASSERT_NR(lbl, clk, prop)
`endif

`endif

FILE: src/dpfr_pkg.sv
package dpfr_pkg;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FAULT = 1'b1;

   localparam logic [1:0] ST_LOADED  = 2'd0;
   localparam logic [1:0] ST_MAP     = 2'd1;
   localparam logic [1:0] ST_OUTSIDE = 2'd2;
   localparam logic [1:0] ST_MAPPED  = 2'd3;

   typedef struct packed {
      logic        operation;
      logic [2:0]  seg_index;
      logic [31:0] seg_base;
      logic [20:0] seg_mem_size;
      logic [20:0] seg_file_size;
      logic [31:0] seg_file_offset;
      logic [2:0]  seg_perm;
      logic [31:0] fault_addr;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] map_addr;
      logic [31:0] file_pos;
      logic [2:0]  page_perm;
      logic [12:0] zero_start;
      logic [12:0] zero_len;
   } rsp_type;

   typedef struct packed {
      logic [31:0] base;
      logic [20:0] mem_bytes;
      logic [20:0] file_bytes;
      logic [31:0] file_offset;
      logic [2:0]  perm;
   } entry_type;

   typedef struct packed {
      logic       load;
      logic       start;
      logic       tbl_rd;
      logic       idx_inc;
      logic       latch_hit;
      logic       row_rd;
      logic       math;
      logic       mark;
      logic       set_res;
      logic [1:0] res_code;
      logic       post;
   } cmd_type;

   typedef struct packed {
      logic limit_zero;
      logic hit;
      logic last;
      logic pidx_ok;
      logic mapped;
   } sts_type;

endpackage

FILE: src/dpfr_ctrl.sv
`include "demand_page_fault_resolver_unit_macros.svh"

module dpfr_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_operation,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dpfr_pkg::cmd_type cmd,
   input  dpfr_pkg::sts_type sts
);
   import dpfr_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TRD  = 3'd1;
   localparam logic [2:0] S_TCMP = 3'd2;
   localparam logic [2:0] S_PCHK = 3'd3;
   localparam logic [2:0] S_MARK = 3'd4;
   localparam logic [2:0] S_POST = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load     = 1'b1;
                  cmd.set_res  = 1'b1;
                  cmd.res_code = ST_LOADED;
                  state_in     = S_POST;
               end else begin
                  cmd.start = 1'b1;
                  if (sts.limit_zero) begin
                     cmd.set_res  = 1'b1;
                     cmd.res_code = ST_OUTSIDE;
                     state_in     = S_POST;
                  end else begin
                     state_in = S_TRD;
                  end
               end
            end
         end
         S_TRD: begin
            cmd.tbl_rd = 1'b1;
            state_in   = S_TCMP;
         end
         S_TCMP: begin
            if (sts.hit) begin
               cmd.latch_hit = 1'b1;
               state_in      = S_PCHK;
            end else if (sts.last) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_OUTSIDE;
               state_in     = S_POST;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = S_TRD;
            end
         end
         S_PCHK: begin
            if (!sts.pidx_ok) begin
               cmd.set_res  = 1'b1;
               cmd.res_code = ST_OUTSIDE;
               state_in     = S_POST;
            end else begin
               cmd.row_rd = 1'b1;
               cmd.math   = 1'b1;
               state_in   = S_MARK;
            end
         end
         S_MARK: begin
            cmd.set_res = 1'b1;
            if (sts.mapped) begin
               cmd.res_code = ST_MAPPED;
            end else begin
               cmd.mark     = 1'b1;
               cmd.res_code = ST_MAP;
            end
            state_in = S_POST;
         end
         S_POST: begin
            if (out_free) begin
               cmd.post = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.post) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `DPFR_ASSERT(a_post_needs_room, clock, reset, cmd.post |-> (!rsp_valid_ff || !rsp_stall))
   `DPFR_ASSERT(a_busy_after_accept, clock, reset, (req_valid && !req_stall) |=> req_stall)
   `DPFR_ASSERT(a_beat_from_post, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == S_POST)
   `DPFR_ASSERT(a_single_write, clock, reset, !(cmd.load && cmd.mark))
   `DPFR_ASSERT_NR(a_reset_clears, clock, reset |=> (!rsp_valid_ff && state_ff == S_IDLE))

endmodule

FILE: src/dpfr_datapath.sv
module dpfr_datapath #(
   parameter int NUM_SEGMENTS      = 8,
   parameter int PAGES_PER_SEGMENT = 256,
   parameter int PAGE_SHIFT        = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  dpfr_pkg::req_type req_data,
   output dpfr_pkg::rsp_type rsp_data,
   input  dpfr_pkg::cmd_type cmd,
   output dpfr_pkg::sts_type sts
);
   import dpfr_pkg::*;

   localparam int SEG_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SEGMENTS + 1);
   localparam int PIDX_W = (PAGES_PER_SEGMENT > 1) ? $clog2(PAGES_PER_SEGMENT) : 1;
   localparam int ZW     = PAGE_SHIFT + 1;
   localparam logic [ZW-1:0] PAGE_BYTES = ZW'(1) << PAGE_SHIFT;
   localparam logic [31:0]   PAGE_MASK  = ~((32'd1 << PAGE_SHIFT) - 32'd1);

   entry_type                tbl_mem [NUM_SEGMENTS];
   logic [PAGES_PER_SEGMENT-1:0] page_mem [NUM_SEGMENTS];

   logic [3:0]                   seg_count_ff;
   logic [NUM_SEGMENTS-1:0]      row_valid_ff;
   logic [SEG_W-1:0]             idx_ff;
   logic [31:0]                  addr_ff;
   entry_type                    tbl_rd_ff;
   logic [31:0]                  diff_ff;
   logic [PAGES_PER_SEGMENT-1:0] row_rd_ff;
   logic                         row_vld_rd_ff;
   logic [31:0]                  map_ff;
   logic [31:0]                  fpos_ff;
   logic [ZW-1:0]                zs_ff;
   logic [ZW-1:0]                ze_ff;
   rsp_type                      res_ff;
   rsp_type                      res_in;
   rsp_type                      out_ff;

   logic [CNT_W-1:0]             limit;
   logic [CNT_W-1:0]             idx_next;
   logic                         load_ok;
   logic [SEG_W-1:0]             wr_idx;
   logic [PIDX_W-1:0]            pidx;
   logic [31:0]                  off;
   logic [ZW-1:0]                zs_in;
   logic [ZW-1:0]                ze_in;
   logic [ZW-1:0]                zl;
   logic [PAGES_PER_SEGMENT-1:0] row_new;
   entry_type                    new_entry;

   function automatic logic [ZW-1:0] clamp_page(input logic [20:0] size,
                                                input logic [31:0] offs);
      logic [33:0] d;
      begin
         d = {13'd0, size} - {2'd0, offs};
         if (d[33]) begin
            clamp_page = '0;
         end else if (d > 34'(PAGE_BYTES)) begin
            clamp_page = PAGE_BYTES;
         end else begin
            clamp_page = ZW'(d);
         end
      end
   endfunction

   assign limit    = (6'(seg_count_ff) > 6'(NUM_SEGMENTS)) ? CNT_W'(NUM_SEGMENTS)
                                                           : CNT_W'(seg_count_ff);
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign load_ok  = 6'(req_data.seg_index) < 6'(NUM_SEGMENTS);
   assign wr_idx   = SEG_W'(req_data.seg_index);
   assign pidx     = diff_ff[PAGE_SHIFT +: PIDX_W];
   assign off      = diff_ff & PAGE_MASK;
   assign zs_in    = clamp_page(tbl_rd_ff.file_bytes, off);
   assign ze_in    = clamp_page(tbl_rd_ff.mem_bytes, off);
   assign zl       = (ze_ff > zs_ff) ? (ze_ff - zs_ff) : '0;
   assign row_new  = (row_vld_rd_ff ? row_rd_ff : '0)
                     | (PAGES_PER_SEGMENT'(1) << pidx);

   assign new_entry.base        = req_data.seg_base;
   assign new_entry.mem_bytes   = req_data.seg_mem_size;
   assign new_entry.file_bytes  = req_data.seg_file_size;
   assign new_entry.file_offset = req_data.seg_file_offset;
   assign new_entry.perm        = req_data.seg_perm;

   assign sts.limit_zero = (limit == '0);
   assign sts.hit        = (addr_ff >= tbl_rd_ff.base)
                           && ({1'b0, addr_ff} < ({1'b0, tbl_rd_ff.base}
                                                   + 33'(tbl_rd_ff.mem_bytes)));
   assign sts.last       = (idx_next == limit);
   assign sts.pidx_ok    = (diff_ff >> PAGE_SHIFT) < 32'(PAGES_PER_SEGMENT);
   assign sts.mapped     = row_vld_rd_ff && row_rd_ff[pidx];

   always_comb begin
      res_in        = '0;
      res_in.status = cmd.res_code;
      if (cmd.res_code == ST_MAP) begin
         res_in.map_addr   = map_ff;
         res_in.file_pos   = fpos_ff;
         res_in.page_perm  = tbl_rd_ff.perm;
         res_in.zero_start = 13'(zs_ff);
         res_in.zero_len   = 13'(zl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= '0;
         row_valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            seg_count_ff <= csr_wr_data;
         end
         if (cmd.load && load_ok) begin
            row_valid_ff[wr_idx] <= 1'b0;
         end else if (cmd.mark) begin
            row_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load && load_ok) begin
         tbl_mem[wr_idx] <= new_entry;
      end
      if (cmd.tbl_rd) begin
         tbl_rd_ff <= tbl_mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mark) begin
         page_mem[idx_ff] <= row_new;
      end
      if (cmd.row_rd) begin
         row_rd_ff     <= page_mem[idx_ff];
         row_vld_rd_ff <= row_valid_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff  <= '0;
         addr_ff <= req_data.fault_addr;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + SEG_W'(1);
      end
      if (cmd.latch_hit) begin
         diff_ff <= addr_ff - tbl_rd_ff.base;
      end
      if (cmd.math) begin
         map_ff  <= tbl_rd_ff.base + off;
         fpos_ff <= tbl_rd_ff.file_offset + off;
         zs_ff   <= zs_in;
         ze_ff   <= ze_in;
      end
      if (cmd.set_res) begin
         res_ff <= res_in;
      end
      if (cmd.post) begin
         out_ff <= res_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

FILE: src/demand_page_fault_resolver_unit.sv
// a load writes its table entry and gives its beat without a search
// a fault searches the table entries in order from entry 0 and stops at the first hit;
//   a hit then checks the page index, reads the page marks and forms the result, or reports
//   outside when the page lies past the tracked pages; a miss reports outside after the last entry
// one item at a time: req_stall stays high until the beat is posted; the search reads one entry at a time
// reset: synchronous active high, clears segment_count, all page mapped bits and the beat
module demand_page_fault_resolver_unit #(
   parameter int NUM_SEGMENTS      = 8,
   parameter int PAGES_PER_SEGMENT = 256,
   parameter int PAGE_SHIFT        = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [3:0]        csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  dpfr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dpfr_pkg::rsp_type rsp_data
);
   import dpfr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dpfr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_data.operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   dpfr_datapath #(
      .NUM_SEGMENTS      (NUM_SEGMENTS),
      .PAGES_PER_SEGMENT (PAGES_PER_SEGMENT),
      .PAGE_SHIFT        (PAGE_SHIFT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

FILE: bench/demand_page_fault_resolver_unit_checker.sv
`timescale 1ns / 1ps
module demand_page_fault_resolver_unit_checker
   import dpfr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [3:0] csr_wr_data,
   input  logic       req_valid,
   input  logic       req_stall,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  rsp_type    rsp_data,
   output int         mismatch_count,
   output int         awaited_count,
   output int         load_beats,
   output int         map_beats,
   output int         outside_beats,
   output int         remap_beats
);

   localparam int     SEGMENTS   = 8;
   localparam int     PAGES      = 256;
   localparam int     PAGE_BITS  = 12;
   localparam longint PAGE_BYTES = 64'sd4096;

   entry_type        seg_table [SEGMENTS];
   logic [PAGES-1:0] page_marked [SEGMENTS];
   logic [3:0]       searched_count;
   rsp_type          predicted_q [$];
   rsp_type          want;

   initial begin
      mismatch_count = 0;
      awaited_count  = 0;
      load_beats     = 0;
      map_beats      = 0;
      outside_beats  = 0;
      remap_beats    = 0;
   end

   function automatic longint clamp_to_page(longint v);
      if (v < 0) return 0;
      if (v > PAGE_BYTES) return PAGE_BYTES;
      return v;
   endfunction

   function automatic rsp_type resolve_request(req_type r);
      rsp_type     res;
      int          limit;
      int          hit;
      logic [32:0] seg_end;
      logic [31:0] pidx;
      longint      used;
      longint      zs;
      longint      ze;
      res = '0;
      res.status = ST_LOADED;
      if (r.operation == OP_LOAD) begin
         seg_table[r.seg_index] = '{r.seg_base, r.seg_mem_size, r.seg_file_size,
                                    r.seg_file_offset, r.seg_perm};
         page_marked[r.seg_index] = '0;
         return res;
      end
      limit = (searched_count > SEGMENTS) ? SEGMENTS : int'(searched_count);
      hit = -1;
      for (int i = 0; i < limit && hit < 0; i++) begin
         // end address kept at 33 bits, no wrap
         seg_end = {1'b0, seg_table[i].base} + 33'(seg_table[i].mem_bytes);
         if (r.fault_addr >= seg_table[i].base && {1'b0, r.fault_addr} < seg_end) begin
            hit = i;
         end
      end
      res.status = ST_OUTSIDE;
      if (hit < 0) return res;
      pidx = (r.fault_addr - seg_table[hit].base) >> PAGE_BITS;
      if (pidx >= PAGES) return res;
      if (page_marked[hit][pidx[7:0]]) begin
         res.status = ST_MAPPED;
         return res;
      end
      page_marked[hit][pidx[7:0]] = 1'b1;
      used = longint'(pidx) << PAGE_BITS;
      zs = clamp_to_page(longint'(seg_table[hit].file_bytes) - used);
      ze = clamp_to_page(longint'(seg_table[hit].mem_bytes) - used);
      res.status     = ST_MAP;
      res.map_addr   = seg_table[hit].base + (pidx << PAGE_BITS);
      res.file_pos   = seg_table[hit].file_offset + (pidx << PAGE_BITS);
      res.page_perm  = seg_table[hit].perm;
      res.zero_start = zs[12:0];
      res.zero_len   = (ze > zs) ? 13'(ze - zs) : 13'd0;
      return res;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] exp_val);
      if (got !== exp_val) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, exp_val));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         searched_count = '0;
         for (int s = 0; s < SEGMENTS; s++) page_marked[s] = '0;
         predicted_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_q.size() == 0) begin
               report_mismatch("result beat with nothing expected");
            end else begin
               want = predicted_q.pop_front();
               check_field("status", 32'(rsp_data.status), 32'(want.status));
               check_field("map_addr", rsp_data.map_addr, want.map_addr);
               check_field("file_pos", rsp_data.file_pos, want.file_pos);
               check_field("page_perm", 32'(rsp_data.page_perm), 32'(want.page_perm));
               check_field("zero_start", 32'(rsp_data.zero_start), 32'(want.zero_start));
               check_field("zero_len", 32'(rsp_data.zero_len), 32'(want.zero_len));
               case (want.status)
                  ST_LOADED: load_beats++;
                  ST_MAP: map_beats++;
                  ST_OUTSIDE: outside_beats++;
                  default: remap_beats++;
               endcase
            end
         end
         if (csr_wr_en) searched_count = csr_wr_data;
         if (req_valid && !req_stall) predicted_q.push_back(resolve_request(req_data));
      end
      awaited_count <= predicted_q.size();
   end

endmodule

FILE: bench/demand_page_fault_resolver_unit_test.sv
`timescale 1ns / 1ps
module demand_page_fault_resolver_unit_test;
   import dpfr_pkg::*;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          SETTLE_CYCLES = 24;
   localparam int          PHASES        = 8;
   localparam logic [31:0] PAGE_BYTES    = 32'h1000;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       csr_wr_en   = 1'b0;
   logic [3:0] csr_wr_data = 4'd0;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   req_type    req_data    = '0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   rsp_type    rsp_data;

   logic        steady       = 1'b0;
   int          cycle_count  = 0;
   int          items_sent   = 0;
   logic [3:0]  active_count = 4'd0;
   logic [31:0] last_fault   = 32'd0;
   entry_type   loaded_seg [8];
   int          phase_count [PHASES] = '{15, 1, 8, 3, 0, 9, 5, 8};

   int mismatch_count;
   int awaited_count;
   int load_beats;
   int map_beats;
   int outside_beats;
   int remap_beats;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) rsp_stall <= !steady && ($urandom_range(99) < 16);

   demand_page_fault_resolver_unit u_dut (.*);

   demand_page_fault_resolver_unit_checker u_checker (.*);

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("demand_page_fault_resolver_unit test failed");
      $finish;
   end

   function automatic req_type random_fields();
      req_type r;
      r.operation       = 1'($urandom_range(1));
      r.seg_index       = 3'($urandom_range(7));
      r.seg_base        = $urandom;
      r.seg_mem_size    = 21'($urandom_range(1048576));
      r.seg_file_size   = 21'($urandom_range(1048576));
      r.seg_file_offset = $urandom;
      r.seg_perm        = 3'($urandom_range(7));
      r.fault_addr      = $urandom;
      return r;
   endfunction

   task automatic send_item(req_type item);
      int gap = 0;
      while (!steady && $urandom_range(99) < 16) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic load_segment(logic [2:0] idx, logic [31:0] base, logic [20:0] mem_bytes,
                               logic [20:0] file_bytes, logic [31:0] offset, logic [2:0] perm);
      req_type r;
      r = random_fields();
      r.operation       = OP_LOAD;
      r.seg_index       = idx;
      r.seg_base        = base;
      r.seg_mem_size    = mem_bytes;
      r.seg_file_size   = file_bytes;
      r.seg_file_offset = offset;
      r.seg_perm        = perm;
      loaded_seg[idx]   = '{base, mem_bytes, file_bytes, offset, perm};
      send_item(r);
   endtask

   task automatic resolve_fault(logic [31:0] addr);
      req_type r;
      r = random_fields();
      r.operation  = OP_FAULT;
      r.fault_addr = addr;
      last_fault   = addr;
      send_item(r);
   endtask

   task automatic set_search_count(logic [3:0] count);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= count;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      active_count  = count;
   endtask

   task automatic load_random_segment();
      logic [31:0] base;
      logic [20:0] mem_bytes;
      logic [20:0] file_bytes;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10) base = 32'hFFFF_FFFF - $urandom_range(32'h6000);
      else if (pick < 25) base = loaded_seg[$urandom_range(7)].base
                                 + PAGE_BYTES * $urandom_range(1);
      else if (pick < 30) base = $urandom_range(32'h3000);
      else base = $urandom;
      pick = $urandom_range(99);
      if (pick < 70) mem_bytes = 21'($urandom_range(6 * 4096));
      else if (pick < 75) mem_bytes = 21'd0;
      else if (pick < 80) mem_bytes = 21'd1048576;
      else mem_bytes = 21'($urandom_range(1048576));
      pick = $urandom_range(99);
      if (pick < 60) file_bytes = 21'($urandom_range(mem_bytes));
      else if (pick < 75) file_bytes = mem_bytes;
      else file_bytes = 21'($urandom_range(1048576));
      load_segment(3'($urandom_range(7)), base, mem_bytes, file_bytes, $urandom,
                   3'($urandom_range(7)));
   endtask

   task automatic fault_random();
      entry_type   seg;
      logic [31:0] addr;
      int          limit;
      int          pick;
      limit = (active_count > 8) ? 8 : int'(active_count);
      pick = $urandom_range(99);
      if (pick < 10) begin
         addr = last_fault;
      end else if (pick < 75 && limit > 0) begin
         seg = loaded_seg[$urandom_range(limit - 1)];
         case ($urandom_range(5))
            0: addr = seg.base;
            1: addr = seg.base + seg.mem_bytes - 1;
            2: addr = seg.base + seg.mem_bytes;
            default: addr = seg.base
                            + ((seg.mem_bytes == 0) ? 0 : $urandom_range(seg.mem_bytes - 1));
         endcase
      end else if (pick < 85) begin
         addr = $urandom_range(32'h000F_FFFF);
      end else begin
         addr = $urandom;
      end
      resolve_fault(addr);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // nothing searched yet
      set_search_count(4'd0);
      resolve_fault(32'h0000_0000);
      resolve_fault(32'hFFFF_FFFF);

      load_segment(3'd0, 32'h0000_0000, 21'd1048576, 21'd0, 32'h0000_0000, 3'd0);
      load_segment(3'd1, 32'hFFFF_F000, 21'h2000, 21'd100, 32'hFFFF_FFFF, 3'd7);
      load_segment(3'd2, 32'h1000_0123, 21'h3000, 21'h1800, 32'h0000_1234, 3'd5);
      load_segment(3'd3, 32'h2000_0000, 21'h1F_FFFF, 21'h1F_FFFF, 32'hABCD_E000, 3'd3);
      load_segment(3'd4, 32'h3000_0000, 21'd0, 21'd0, 32'h5555_5555, 3'd1);
      load_segment(3'd5, 32'h4000_0000, 21'h2000, 21'h5000, 32'hAAAA_A000, 3'd2);
      load_segment(3'd6, 32'h1000_0123, 21'h1000, 21'h0800, 32'h7777_7000, 3'd4);
      load_segment(3'd7, 32'h5000_0000, 21'h1000, 21'h1000, 32'h8000_0000, 3'd6);

      // count above the table size
      set_search_count(4'd15);
      resolve_fault(32'h0000_0000);
      resolve_fault(32'h000F_FFFF);
      resolve_fault(32'h0000_0FFF);
      resolve_fault(32'hFFFF_FFFF);
      resolve_fault(32'h1000_1123);
      resolve_fault(32'h1000_3122);
      resolve_fault(32'h2010_0000);
      resolve_fault(32'h201F_FFFE);
      resolve_fault(32'h3000_0000);
      resolve_fault(32'h4000_1000);
      resolve_fault(32'h5000_0FFF);
      resolve_fault(32'h6000_0000);
      // reload clears the page marks
      load_segment(3'd0, 32'h0000_0000, 21'd1048576, 21'd0, 32'h0000_0000, 3'd0);
      resolve_fault(32'h0000_0000);

      for (int p = 0; p < PHASES; p++) begin
         set_search_count(4'(phase_count[p]));
         steady <= (p == 2);
         repeat (110) begin
            if ($urandom_range(99) < 20) load_random_segment();
            else fault_random();
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("sent %0d items over %0d search count settings", items_sent, PHASES + 2);
      $display("beats: %0d loads, %0d pages mapped, %0d outside, %0d already mapped",
               load_beats, map_beats, outside_beats, remap_beats);
      if (mismatch_count == 0 && awaited_count == 0) begin
         $display("demand_page_fault_resolver_unit test passed");
      end else begin
         $display("demand_page_fault_resolver_unit test failed");
      end
      $finish;
   end

endmodule
